// ===== rtl/ntcsd_pkg.sv =====
`default_nettype none
package ntcsd_pkg;

  localparam int TABLE_DEPTH = 100;
  localparam int RAW_W = $clog2(TABLE_DEPTH + 1);
  localparam int HELD_W = 7;
  localparam int CALC_W = (RAW_W > HELD_W ? RAW_W : HELD_W) + 1;
  localparam int SAMPLE_W = 12;
  localparam int HELD_DEPTH = 1;

  localparam logic [SAMPLE_W-1:0] TABLE_TOP = 12'd3815;
  localparam logic [SAMPLE_W-1:0] TABLE_STEP = 12'd27;
  localparam logic [HELD_W-1:0] SHOW_MAX = 7'd99;

  localparam logic [6:0] SEG_BLANK = 7'h00;
  localparam logic [6:0] SEG_UNIT_C = 7'h0D;

  localparam logic [1:0] POS_TENS = 2'd1;
  localparam logic [1:0] POS_ONES = 2'd2;
  localparam logic [1:0] POS_UNIT = 2'd3;

  localparam logic [2:0] SEL_TENS = 3'd3;
  localparam logic [2:0] SEL_ONES = 3'd5;
  localparam logic [2:0] SEL_UNIT = 3'd6;

  localparam logic [0:0] REG_DISPLAY_ENABLE = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_UPD  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  function automatic logic [6:0] digit_seg(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0: s = 7'h7E;
      4'd1: s = 7'h12;
      4'd2: s = 7'h67;
      4'd3: s = 7'h57;
      4'd4: s = 7'h1B;
      4'd5: s = 7'h5D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h16;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h5F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ntc_temperature_segment_display.sv =====
// Thermistor readout for a three-position multiplexed seven-segment display.
// Input channel: in_valid_i, in_stall_o and adc_sample_i carry one 12-bit
// reading per word. Output channel: out_valid_o, out_stall_i and the display
// fields carry one word per position; each enabled reading yields three words
// in the order tens digit, ones digit, unit symbol, with last_digit high on
// the third. Words are taken while display_enable is zero but are dropped.
// The table is scanned one entry per cycle from a step counter until the scan
// ends at the raw temperature t (0 to 100); the held temperature is then
// updated and the first word loaded; the other two words follow one per cycle
// while the receiver does not stall. The held temperature lives in a
// one-entry RAM that is read when an enabled reading is taken and written
// back after the scan; a valid flag makes it read as zero after reset.
// The block takes the next reading once the third word is loaded.
// Reset clears the enable register, the held temperature and all control.
// A stall holds the output word; the block waits until it is taken.
`default_nettype none
module ntc_temperature_segment_display
  import ntcsd_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [11:0]   adc_sample_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic      [1:0]    digit_position_o,
  output logic      [6:0]    segment_bits_o,
  output logic      [2:0]    digit_select_o,
  output logic      [6:0]    shown_value_o,
  output logic               last_digit_o
);

  state_e state_q, state_d;
  logic enable_q;
  logic held_vld_q;
  logic [SAMPLE_W-1:0] sample_q, entry_q;
  logic [RAW_W-1:0] idx_q;
  logic [HELD_W-1:0] shown_q;
  logic [3:0] tens_q;
  logic [1:0] pos_q;
  logic out_valid_q;
  logic [1:0] pos_out_q;
  logic [6:0] seg_out_q;
  logic [2:0] sel_out_q;
  logic [6:0] shown_out_q;
  logic last_out_q;

  logic in_acc, start, scan_done, load;
  logic [HELD_W-1:0] ram_rdata, held_cur, held_new, shown_d;
  logic [CALC_W-1:0] raw_x, held_x, held_n;
  logic [14:0] tens_prod;
  logic [HELD_W-1:0] tens_times;
  logic [3:0] ones;

  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_DISPLAY_ENABLE) ? {31'd0, enable_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2:2] == REG_DISPLAY_ENABLE) begin
      enable_q <= pwdata[0];
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign start = in_acc && enable_q;
  assign scan_done = (idx_q == RAW_W'(TABLE_DEPTH)) || (entry_q < sample_q);
  assign load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  ntcsd_ram #(.WIDTH(HELD_W), .DEPTH(HELD_DEPTH)) u_held_ram (
    .clk_i  (clk_i),
    .we_i   (state_q == S_UPD),
    .waddr_i(1'b0),
    .wdata_i(held_new),
    .re_i   (start),
    .raddr_i(1'b0),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    held_cur = held_vld_q ? ram_rdata : '0;
    raw_x = CALC_W'(idx_q);
    held_x = CALC_W'(held_cur);
    held_n = held_x;
    if (raw_x > held_x + CALC_W'(1)) begin
      held_n = raw_x - CALC_W'(1);
    end else if (raw_x + CALC_W'(1) < held_x) begin
      held_n = raw_x + CALC_W'(1);
    end
    if (raw_x == CALC_W'(99)) begin
      held_n = CALC_W'(99);
    end
    if (raw_x == '0) begin
      held_n = '0;
    end
    held_new = held_n[HELD_W-1:0];
    shown_d = (held_new > SHOW_MAX) ? SHOW_MAX : held_new;
    tens_prod = 15'(shown_d) * 15'd205;
  end

  assign tens_times = 7'({tens_q, 3'b000}) + 7'({tens_q, 1'b0});
  assign ones = 4'(shown_q - tens_times);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start) state_d = S_SCAN;
      S_SCAN: if (scan_done) state_d = S_UPD;
      S_UPD:  state_d = S_OUT;
      S_OUT:  if (load && pos_q == POS_UNIT) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      held_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q <= POS_TENS;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_UPD) begin
        held_vld_q <= 1'b1;
      end
      if (start) begin
        idx_q <= '0;
      end else if (state_q == S_SCAN && !scan_done) begin
        idx_q <= idx_q + RAW_W'(1);
      end
      if (state_q == S_UPD) begin
        pos_q <= POS_TENS;
      end else if (load) begin
        pos_q <= pos_q + 2'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      sample_q <= adc_sample_i;
      entry_q <= TABLE_TOP;
    end else if (state_q == S_SCAN && !scan_done) begin
      entry_q <= entry_q - TABLE_STEP;
    end
    if (state_q == S_UPD) begin
      shown_q <= shown_d;
      tens_q <= tens_prod[14:11];
    end
    if (load) begin
      pos_out_q <= pos_q;
      shown_out_q <= shown_q;
      last_out_q <= (pos_q == POS_UNIT);
      case (pos_q)
        POS_TENS: begin
          seg_out_q <= (tens_q == 4'd0) ? SEG_BLANK : digit_seg(tens_q);
          sel_out_q <= SEL_TENS;
        end
        POS_ONES: begin
          seg_out_q <= digit_seg(ones);
          sel_out_q <= SEL_ONES;
        end
        default: begin
          seg_out_q <= SEG_UNIT_C;
          sel_out_q <= SEL_UNIT;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign digit_position_o = pos_out_q;
  assign segment_bits_o = seg_out_q;
  assign digit_select_o = sel_out_q;
  assign shown_value_o = shown_out_q;
  assign last_digit_o = last_out_q;

endmodule
`default_nettype wire

// ===== rtl/ntcsd_ram.sv =====
`default_nettype none
module ntcsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import ntcsd_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] ADDR_ENABLE = {REG_DISPLAY_ENABLE, 2'b00};
  localparam logic [2:0] ADDR_SPARE = 3'd4;
  localparam logic [69:0] DIGIT_CODES = {
    7'h5F, 7'h7F, 7'h16, 7'h7D, 7'h5D, 7'h1B, 7'h57, 7'h67, 7'h12, 7'h7E
  };

  typedef struct packed {
    logic [1:0] pos;
    logic [6:0] seg;
    logic [2:0] sel;
    logic [6:0] shown;
    logic       last;
  } display_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] adc_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  digit_position;
  logic [6:0]  segment_bits;
  logic [2:0]  digit_select;
  logic [6:0]  shown_value;
  logic        last_digit;

  display_word_t display_words[$];
  logic          model_enable = 1'b0;
  logic [6:0]    model_held = '0;
  int            send_idle_pct = 0;
  int            stall_pct = 0;
  int            hold_left = 0;
  int            idle_cycles = 0;
  int            errors = 0;

  always #5 clk_i = ~clk_i;

  ntc_temperature_segment_display u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .adc_sample_i     (adc_sample),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .digit_position_o (digit_position),
    .segment_bits_o   (segment_bits),
    .digit_select_o   (digit_select),
    .shown_value_o    (shown_value),
    .last_digit_o     (last_digit)
  );

  function automatic int raw_temperature(input logic [11:0] s);
    int i;
    i = 0;
    while (i < TABLE_DEPTH && int'(TABLE_TOP) - int'(TABLE_STEP) * i >= int'(s)) i++;
    return i;
  endfunction

  // Lowest reading that maps to temperature t, for t below 100.
  function automatic logic [11:0] sample_for(input int t);
    return 12'(int'(TABLE_TOP) + 1 - int'(TABLE_STEP) * t);
  endfunction

  function automatic logic [11:0] pick_sample();
    int roll;
    int t;
    roll = $urandom_range(99);
    if (roll < 15) return 12'($urandom_range(4095));
    if (roll < 30) t = int'($urandom_range(100));
    else t = int'(model_held) + int'($urandom_range(6)) - 3;
    if (t <= 0) return 12'(int'(TABLE_TOP) + 1 + int'($urandom_range(279)));
    if (t >= TABLE_DEPTH) return 12'($urandom_range(int'(sample_for(TABLE_DEPTH))));
    return 12'(int'(sample_for(t)) + int'($urandom_range(26)));
  endfunction

  task automatic predict_display(input logic [11:0] s);
    int raw;
    int held;
    int shown;
    display_word_t w;
    raw = raw_temperature(s);
    held = int'(model_held);
    if (raw >= held + 2) held = raw - 1;
    else if (raw + 2 <= held) held = raw + 1;
    if (raw == 99) held = 99;
    if (raw == 0) held = 0;
    model_held = 7'(held);
    shown = (held > int'(SHOW_MAX)) ? int'(SHOW_MAX) : held;
    w.shown = 7'(shown);
    w.pos = POS_TENS;
    w.seg = (shown / 10 == 0) ? SEG_BLANK : DIGIT_CODES[(shown / 10) * 7 +: 7];
    w.sel = SEL_TENS;
    w.last = 1'b0;
    display_words.push_back(w);
    w.pos = POS_ONES;
    w.seg = DIGIT_CODES[(shown % 10) * 7 +: 7];
    w.sel = SEL_ONES;
    display_words.push_back(w);
    w.pos = POS_UNIT;
    w.seg = SEG_UNIT_C;
    w.sel = SEL_UNIT;
    w.last = 1'b1;
    display_words.push_back(w);
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin : check_words
    display_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (display_words.size() == 0) begin
        report_mismatch("word with none expected, position", digit_position, 0);
      end else begin
        want = display_words.pop_front();
        if (digit_position !== want.pos)
          report_mismatch("digit_position", digit_position, want.pos);
        if (segment_bits !== want.seg)
          report_mismatch("segment_bits", segment_bits, want.seg);
        if (digit_select !== want.sel)
          report_mismatch("digit_select", digit_select, want.sel);
        if (shown_value !== want.shown)
          report_mismatch("shown_value", shown_value, want.shown);
        if (last_digit !== want.last)
          report_mismatch("last_digit", last_digit, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ntc_temperature_segment_display regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_ENABLE) model_enable = data[0];
  endtask

  task automatic send_sample(input logic [11:0] s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    adc_sample <= s;
    do @(posedge clk_i); while (in_stall);
    if (model_enable) predict_display(s);
  endtask

  task automatic drain_display();
    in_valid <= 1'b0;
    while (display_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_disabled();
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(ADDR_SPARE, 32'hFFFF_FFFF);
    send_sample(12'hFFF);
    send_sample(12'h000);
    send_sample(12'd2000);
    drain_display();
  endtask

  task automatic test_directed();
    int sweep[9] = '{12, 23, 34, 45, 56, 67, 78, 89, 99};
    int steps[5] = '{50, 51, 52, 53, 50};
    write_reg(ADDR_ENABLE, 32'hFFFF_FFFF);
    send_sample(12'hFFF);
    send_sample(12'h000);
    send_sample(12'd1142);
    send_sample(12'd1143);
    send_sample(TABLE_TOP);
    send_sample(TABLE_TOP + 12'd1);
    foreach (sweep[i]) send_sample(sample_for(sweep[i]));
    foreach (steps[i]) send_sample(sample_for(steps[i]));
    send_sample(sample_for(5));
    drain_display();
  endtask

  task automatic test_random(input int idle, input int stall, input int count);
    write_reg(ADDR_ENABLE, $urandom | 32'h1);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_sample(pick_sample());
    drain_display();
  endtask

  task automatic test_disabled_random();
    write_reg(ADDR_ENABLE, $urandom & 32'hFFFF_FFFE);
    send_idle_pct = 20;
    stall_pct = 20;
    repeat (20) send_sample(pick_sample());
    drain_display();
  endtask

  task automatic test_pressure();
    write_reg(ADDR_ENABLE, $urandom | 32'h1);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (8) send_sample(pick_sample());
    drain_display();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_disabled();
    test_directed();
    test_random(0, 0, 40);
    test_random(58, 0, 40);
    test_disabled_random();
    test_random(0, 58, 40);
    test_pressure();
    test_random(6, 6, 40);
    if (errors == 0) begin
      $display("ntc_temperature_segment_display regression: pass");
    end else begin
      $display("ntc_temperature_segment_display regression: fail");
    end
    $finish;
  end

endmodule
